### design/escape_byte_stuffing_deframer_assert.svh
// assertion macros for the escape byte-stuffing deframer checker
// expects clk and rst_n in the scope where a macro is used
`ifndef ESCAPE_BYTE_STUFFING_DEFRAMER_ASSERT_SVH
`define ESCAPE_BYTE_STUFFING_DEFRAMER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define EBSD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer check failed");

// next-cycle implication, disabled during reset
`define EBSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

### design/ebsd_pkg.sv
// shared types and constants of the escape byte-stuffing deframer
// no dependencies
package ebsd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned FillW  = 11;
  localparam int unsigned IndexW = 10;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 11;

  localparam logic [FillW-1:0] MaxFrameBytes   = 11'd1024;
  localparam logic [FillW-1:0] CapacityAtReset = 11'd1024;

  localparam logic [ByteW-1:0] EscCode   = 8'h5C;
  localparam logic [ByteW-1:0] EndCode   = 8'h65;
  localparam logic [ByteW-1:0] StartCode = 8'h73;

  localparam logic [CfgIdxW-1:0] CfgFrameCapacity = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgReceiveEnable = 1'd1;

  typedef enum logic [1:0] {
    CAUSE_VALID     = 2'd0,
    CAUSE_FULL      = 2'd1,
    CAUSE_FRAME_ERR = 2'd2,
    CAUSE_LINE_ERR  = 2'd3
  } cause_t;

  typedef struct packed {
    logic [ByteW-1:0] rx_byte;
    logic             line_error;
  } in_item_t;

  typedef struct packed {
    logic [ByteW-1:0]  data_byte;
    logic              data_valid;
    logic [IndexW-1:0] data_index;
    logic              event_valid;
    logic [1:0]        event_cause;
    logic [FillW-1:0]  frame_length;
  } out_item_t;

  // register file contents seen by the decoder
  typedef struct packed {
    logic [FillW-1:0] frame_capacity;
    logic             receive_enable;
  } cfg_t;

  // held input item handed to the decoder
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } stage_t;

endpackage

### design/ebsd_if.sv
// valid/ready channel interfaces for the deframer input and result streams
// depends on ebsd_pkg
interface ebsd_in_if;
  logic                valid;
  logic                ready;
  ebsd_pkg::in_item_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface ebsd_out_if;
  logic                valid;
  logic                ready;
  ebsd_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### design/ebsd_cfg.sv
// configuration registers: frame capacity and receive enable
// depends on ebsd_pkg
module ebsd_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ebsd_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [ebsd_pkg::CfgDataW-1:0] cfg_wdata,
  output ebsd_pkg::cfg_t                cfg
);

  logic [ebsd_pkg::FillW-1:0] capacity_r;
  logic                       enable_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= ebsd_pkg::CapacityAtReset;
      enable_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ebsd_pkg::CfgFrameCapacity: capacity_r <= cfg_wdata[ebsd_pkg::FillW-1:0];
        ebsd_pkg::CfgReceiveEnable: enable_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg.frame_capacity = capacity_r;
  assign cfg.receive_enable = enable_r;

endmodule

### design/ebsd_in_stage.sv
// input register: takes a transfer whenever empty or being drained
// depends on ebsd_pkg and ebsd_if
module ebsd_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  ebsd_in_if.sink         in_ch,
  input  logic            advance,
  output ebsd_pkg::stage_t stage
);

  logic               valid_r, valid_nxt;
  ebsd_pkg::in_item_t item_r;
  logic               take;

  assign in_ch.ready = !valid_r || advance;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_ch.payload;
    end
  end

  assign stage.valid = valid_r;
  assign stage.item  = item_r;

endmodule

### design/ebsd_decode.sv
// escape decoder: frame state, fill counter and the result register
// depends on ebsd_pkg and ebsd_if
module ebsd_decode (
  input  logic             clk,
  input  logic             rst_n,
  input  ebsd_pkg::cfg_t   cfg,
  input  ebsd_pkg::stage_t stage,
  output logic             advance,
  ebsd_out_if.source       out_ch
);

  logic                       esc_r, esc_nxt;
  logic [ebsd_pkg::FillW-1:0] fill_r, fill_nxt;
  logic                       out_valid_r, out_valid_nxt;
  ebsd_pkg::out_item_t        out_item_r;

  ebsd_pkg::out_item_t        res;
  logic                       has_res;
  logic [ebsd_pkg::FillW-1:0] cap_eff;
  logic [ebsd_pkg::FillW-1:0] fill_inc;
  logic [ebsd_pkg::ByteW-1:0] b;

  assign advance  = stage.valid && (!out_valid_r || out_ch.ready);
  assign b        = stage.item.rx_byte;
  assign cap_eff  = (cfg.frame_capacity > ebsd_pkg::MaxFrameBytes) ?
                    ebsd_pkg::MaxFrameBytes : cfg.frame_capacity;
  // fill stays below 1024 at rest, so the increment cannot wrap
  assign fill_inc = fill_r + 11'd1;

  always_comb begin
    res      = '0;
    has_res  = 1'b0;
    esc_nxt  = esc_r;
    fill_nxt = fill_r;
    if (stage.item.line_error) begin
      // escape flag survives a line error
      has_res          = 1'b1;
      res.event_valid  = 1'b1;
      res.event_cause  = ebsd_pkg::CAUSE_LINE_ERR;
      res.frame_length = fill_r;
      fill_nxt         = '0;
    end else if (!cfg.receive_enable) begin
      has_res = 1'b0;
    end else if (!esc_r && b == ebsd_pkg::EscCode) begin
      esc_nxt = 1'b1;
    end else if (esc_r && b == ebsd_pkg::EndCode) begin
      esc_nxt          = 1'b0;
      has_res          = 1'b1;
      res.event_valid  = 1'b1;
      res.event_cause  = ebsd_pkg::CAUSE_VALID;
      res.frame_length = fill_r;
      fill_nxt         = '0;
    end else if (esc_r && b == ebsd_pkg::StartCode) begin
      esc_nxt  = 1'b0;
      fill_nxt = '0;
    end else if (esc_r && b != ebsd_pkg::EscCode) begin
      esc_nxt         = 1'b0;
      has_res         = 1'b1;
      res.event_valid = 1'b1;
      res.event_cause = ebsd_pkg::CAUSE_FRAME_ERR;
      fill_nxt        = '0;
    end else begin
      // payload byte, plain or escaped literal
      esc_nxt        = 1'b0;
      has_res        = 1'b1;
      res.data_byte  = b;
      res.data_valid = 1'b1;
      res.data_index = fill_r[ebsd_pkg::IndexW-1:0];
      if (fill_inc >= cap_eff) begin
        res.event_valid  = 1'b1;
        res.event_cause  = ebsd_pkg::CAUSE_FULL;
        res.frame_length = fill_inc;
        fill_nxt         = '0;
      end else begin
        fill_nxt = fill_inc;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance && has_res) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r       <= 1'b0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        esc_r  <= esc_nxt;
        fill_r <= fill_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_res) begin
      out_item_r <= res;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_item_r;

endmodule

### design/escape_byte_stuffing_deframer.sv
// Escape byte-stuffing deframer for a serial receive stream.
// Channels: in_rx carries one received byte with its line-error flag per
// transfer; out_res carries at most one result per input transfer: a payload
// byte with its frame index, a frame event (end, buffer full, frame error,
// line error), or both when the byte fills the frame.
// Configuration: cfg_we/cfg_index/cfg_wdata write frame_capacity (index 0)
// and receive_enable (index 1); write only while no transfer is in flight.
// Path: an input transfer is held in the input register and its result is
// then held in the result register, which drives out_res.
// Throughput: one input transfer per cycle while out_res is not stalled; the
// escape flag and fill counter are updated as each held byte is decoded.
// Reset (rst_n low, synchronous): capacity 1024, reception disabled, escape
// flag and fill count cleared, both stages empty.
// Receiver stall: the result register holds its item; the input register
// still takes one more transfer, after which in_rx.ready drops until the
// result is taken. Inputs that make no result never wait on the receiver
// unless a result is already parked ahead of them.
// Depends on ebsd_pkg, ebsd_if, ebsd_cfg, ebsd_in_stage and ebsd_decode.
module escape_byte_stuffing_deframer (
  input  logic                          clk,
  input  logic                          rst_n,
  ebsd_in_if.sink                       in_rx,
  ebsd_out_if.source                    out_res,
  input  logic                          cfg_we,
  input  logic [ebsd_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [ebsd_pkg::CfgDataW-1:0] cfg_wdata
);

  ebsd_pkg::cfg_t   cfg;
  ebsd_pkg::stage_t stage;
  logic             advance;

  ebsd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ebsd_in_stage u_in_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_rx),
    .advance (advance),
    .stage   (stage)
  );

  ebsd_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .stage   (stage),
    .advance (advance),
    .out_ch  (out_res)
  );

endmodule

### design/ebsd_checker.sv
// port-level checks of the deframer result stream, bound to the top level
// depends on ebsd_pkg and escape_byte_stuffing_deframer_assert.svh
`include "escape_byte_stuffing_deframer_assert.svh"

module ebsd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input ebsd_pkg::out_item_t out_item
);

  // every result carries a byte, an event or both
  `EBSD_ASSERT_NOW(a_res_nonempty, out_valid, out_item.data_valid || out_item.event_valid)

  // a byte and an event together only when the byte fills the frame
  `EBSD_ASSERT_NOW(a_both_is_full, out_valid && out_item.data_valid && out_item.event_valid,
    out_item.event_cause == ebsd_pkg::CAUSE_FULL)

  // frame errors report no length and no byte
  `EBSD_ASSERT_NOW(a_frame_err_len,
    out_valid && out_item.event_valid && out_item.event_cause == ebsd_pkg::CAUSE_FRAME_ERR,
    out_item.frame_length == '0 && !out_item.data_valid)

  // a stalled result holds
  `EBSD_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready,
    out_valid && $stable(out_item))

endmodule

bind escape_byte_stuffing_deframer ebsd_checker u_ebsd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_res.valid),
  .out_ready (out_res.ready),
  .out_item  (out_res.payload)
);
